/* design/two_pool_page_free_stack_assert.svh */
// ----------------------------------------------------------------------------
// two_pool_page_free_stack_assert.svh
// Assertion macros shared by the page allocator modules.
// ----------------------------------------------------------------------------
`ifndef TWO_POOL_PAGE_FREE_STACK_ASSERT_SVH
`define TWO_POOL_PAGE_FREE_STACK_ASSERT_SVH

`ifndef SYNTH
// prop must hold at every clock edge out of reset
`define TPFS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("two_pool_page_free_stack: assertion failed");
// expr must never be true out of reset
`define TPFS_NEVER(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("two_pool_page_free_stack: forbidden condition seen");
`else
`define TPFS_ASSERT(label, prop)
`define TPFS_NEVER(label, expr)
`endif

`endif

/* design/tpfs_pkg.sv */
// ----------------------------------------------------------------------------
// tpfs_pkg
// Constants, codes and interface types of the two-pool page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpfs_pkg;

    localparam int POOL_PAGES = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_BITS  = 40;

    // fixed field widths
    localparam int PAGE_W   = 28;
    localparam int ADDR_W   = 40;
    localparam int KPAGES_W = 11;
    localparam int FCOUNT_W = 11;
    localparam int STATUS_W = 3;
    localparam int REQ_W    = 2;

    localparam int SLOT_W    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int COUNT_W   = $clog2(POOL_PAGES + 1);
    localparam int RAM_DEPTH = 2 * (2 ** SLOT_W);

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    // configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;
    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_END    = 2'd1;
    localparam logic [1:0] CFG_KPAGES = 2'd2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CFG    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

    typedef struct packed {
        logic [PAGE_W-1:0]  low;
        logic [PAGE_W-1:0]  high;
        logic [COUNT_W-1:0] size;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] mark;
    } pool_t;

    typedef struct packed {
        logic load_req;
        logic commit;
        logic from_mem;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_mem;
        logic out_busy;
    } dp_sts_t;

    typedef struct packed {
        logic              en;
        logic [1:0]        idx;
        logic [CFG_DW-1:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

/* design/tpfs_ram.sv */
// ----------------------------------------------------------------------------
// tpfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfs_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/tpfs_dpath.sv */
// ----------------------------------------------------------------------------
// tpfs_dpath
// Datapath: config registers, pool descriptors, request and result registers,
// and the shared stack memory (kernel pool in the upper half).
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_pool_page_free_stack_assert.svh"

module tpfs_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tpfs_pkg::REQ_W-1:0]    s_req_type,
    input  logic                          s_in_kernel,
    input  logic [tpfs_pkg::ADDR_W-1:0]   s_page_addr,
    input  tpfs_pkg::ctl_cmd_t            cmd,
    output tpfs_pkg::dp_sts_t             sts,
    input  tpfs_pkg::cfg_wr_t             cfg_wr,
    input  logic [1:0]                    cfg_rd_idx,
    output logic [tpfs_pkg::CFG_DW-1:0]   cfg_rdata,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [tpfs_pkg::STATUS_W-1:0] m_status,
    output logic [tpfs_pkg::ADDR_W-1:0]   m_alloc_addr,
    output logic [tpfs_pkg::FCOUNT_W-1:0] m_free_count
);

    localparam int PW = tpfs_pkg::PAGE_W;
    localparam int CW = tpfs_pkg::COUNT_W;
    localparam int AW = tpfs_pkg::ADDR_W;

    // configuration
    logic [PW-1:0]                 cfg_start_reg;
    logic [PW-1:0]                 cfg_end_reg;
    logic [tpfs_pkg::KPAGES_W-1:0] cfg_kpages_reg;
    logic [PW-1:0]                 span_reg;
    logic                          start_gt_end_reg;

    // request
    logic [tpfs_pkg::REQ_W-1:0] req_type_reg;
    logic                       req_kernel_reg;
    logic [AW-1:0]              req_addr_reg;

    // pools
    tpfs_pkg::pool_t kpool_reg, kpool_next;
    tpfs_pkg::pool_t upool_reg, upool_next;

    // result
    logic                          m_valid_reg, m_valid_next;
    logic [tpfs_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [AW-1:0]                 m_alloc_addr_reg, m_alloc_addr_next;
    logic [tpfs_pkg::FCOUNT_W-1:0] m_free_count_reg, m_free_count_next;

    tpfs_pkg::pool_t cur, cur_new, knew, unew;
    logic [CW-1:0]   slot;
    logic            empty, below_mark;
    logic [PW-1:0]   gen_page, ram_rdata, alloc_page;
    logic [AW-1:0]   free_addr, free_page;
    logic            misaligned, out_range, pool_full;
    logic [PW-1:0]   kp_ext, user_span, kern_hi;
    logic            init_ok;
    logic            push;
    logic [tpfs_pkg::STATUS_W-1:0] res_status;
    logic [AW-1:0]   res_addr;
    logic [CW-1:0]   res_count;

    function automatic logic [AW-1:0] page_to_addr(input logic [PW-1:0] page);
        logic [63:0] wide;
        wide = 64'(page) << tpfs_pkg::PAGE_SHIFT;
        return AW'(wide) & tpfs_pkg::ADDR_MASK;
    endfunction

    // ------------------------------------------------------------ config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_start_reg  <= '0;
            cfg_end_reg    <= '0;
            cfg_kpages_reg <= '0;
        end else if (cfg_wr.en) begin
            case (cfg_wr.idx)
                tpfs_pkg::CFG_START:  cfg_start_reg  <= PW'(cfg_wr.data);
                tpfs_pkg::CFG_END:    cfg_end_reg    <= PW'(cfg_wr.data);
                tpfs_pkg::CFG_KPAGES: cfg_kpages_reg <= tpfs_pkg::KPAGES_W'(cfg_wr.data);
                default: ;
            endcase
        end
    end

    // region span is precomputed so init only does one subtract
    always_ff @(posedge aclk) begin
        span_reg         <= cfg_end_reg - cfg_start_reg;
        start_gt_end_reg <= cfg_start_reg > cfg_end_reg;
    end

    always_comb begin
        case (cfg_rd_idx)
            tpfs_pkg::CFG_START:  cfg_rdata = tpfs_pkg::CFG_DW'(cfg_start_reg);
            tpfs_pkg::CFG_END:    cfg_rdata = tpfs_pkg::CFG_DW'(cfg_end_reg);
            tpfs_pkg::CFG_KPAGES: cfg_rdata = tpfs_pkg::CFG_DW'(cfg_kpages_reg);
            default:              cfg_rdata = '0;
        endcase
    end

    // ------------------------------------------------------------ request
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_type_reg   <= s_req_type;
            req_kernel_reg <= s_in_kernel;
            req_addr_reg   <= s_page_addr;
        end
    end

    // ------------------------------------------------------------ decode
    assign cur        = req_kernel_reg ? kpool_reg : upool_reg;
    assign slot       = cur.count - CW'(1);
    assign empty      = (cur.count == '0);
    // slots under the mark were never written: page is low + slot
    assign below_mark = (slot < cur.mark);
    assign gen_page   = cur.low + PW'(slot);
    assign alloc_page = cmd.from_mem ? ram_rdata : gen_page;

    assign free_addr  = req_addr_reg & tpfs_pkg::ADDR_MASK;
    assign free_page  = free_addr >> tpfs_pkg::PAGE_SHIFT;
    assign misaligned = |free_addr[tpfs_pkg::PAGE_SHIFT-1:0];
    assign out_range  = (free_page < AW'(cur.low)) || (free_page >= AW'(cur.high));
    assign pool_full  = (cur.count >= cur.size);

    assign kp_ext    = PW'(cfg_kpages_reg);
    assign user_span = span_reg - kp_ext;
    assign kern_hi   = cfg_start_reg + kp_ext;
    assign init_ok   = !start_gt_end_reg && (kp_ext <= span_reg)
                       && (32'(cfg_kpages_reg) <= tpfs_pkg::POOL_PAGES)
                       && (user_span <= PW'(tpfs_pkg::POOL_PAGES));

    always_comb begin
        cur_new    = cur;
        knew       = kpool_reg;
        unew       = upool_reg;
        res_status = tpfs_pkg::ST_OK;
        res_addr   = '0;
        push       = 1'b0;
        case (req_type_reg)
            tpfs_pkg::REQ_INIT: begin
                if (init_ok) begin
                    knew.low   = cfg_start_reg;
                    knew.high  = kern_hi;
                    knew.size  = CW'(cfg_kpages_reg);
                    knew.count = CW'(cfg_kpages_reg);
                    knew.mark  = CW'(cfg_kpages_reg);
                    unew.low   = kern_hi;
                    unew.high  = cfg_end_reg;
                    unew.size  = CW'(user_span);
                    unew.count = CW'(user_span);
                    unew.mark  = CW'(user_span);
                end else begin
                    res_status = tpfs_pkg::ST_BAD_CFG;
                end
            end
            tpfs_pkg::REQ_ALLOC: begin
                if (empty) begin
                    res_status = tpfs_pkg::ST_EXHAUSTED;
                end else begin
                    cur_new.count = slot;
                    if (below_mark) begin
                        cur_new.mark = slot;
                    end
                    res_addr = page_to_addr(alloc_page);
                end
            end
            tpfs_pkg::REQ_FREE: begin
                if (misaligned) begin
                    res_status = tpfs_pkg::ST_MISALIGNED;
                end else if (out_range) begin
                    res_status = tpfs_pkg::ST_RANGE;
                end else if (pool_full) begin
                    res_status = tpfs_pkg::ST_FULL;
                end else begin
                    push          = 1'b1;
                    cur_new.count = cur.count + CW'(1);
                end
            end
            default: ;
        endcase
        if (req_type_reg != tpfs_pkg::REQ_INIT) begin
            if (req_kernel_reg) begin
                knew = cur_new;
            end else begin
                unew = cur_new;
            end
        end
        res_count = req_kernel_reg ? knew.count : unew.count;
    end

    assign sts.need_mem = (req_type_reg == tpfs_pkg::REQ_ALLOC) && !empty && !below_mark;
    assign sts.out_busy = m_valid_reg && !m_ready;

    // ------------------------------------------------------------ stack memory
    tpfs_ram #(
        .WIDTH (PW),
        .DEPTH (tpfs_pkg::RAM_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (cmd.commit && push),
        .waddr ({req_kernel_reg, cur.count[tpfs_pkg::SLOT_W-1:0]}),
        .wdata (free_page[PW-1:0]),
        .raddr ({req_kernel_reg, slot[tpfs_pkg::SLOT_W-1:0]}),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------ state update
    always_comb begin
        kpool_next        = cmd.commit ? knew : kpool_reg;
        upool_next        = cmd.commit ? unew : upool_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_alloc_addr_next = m_alloc_addr_reg;
        m_free_count_next = m_free_count_reg;
        if (cmd.commit) begin
            m_valid_next      = 1'b1;
            m_status_next     = res_status;
            m_alloc_addr_next = res_addr;
            m_free_count_next = tpfs_pkg::FCOUNT_W'(res_count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kpool_reg   <= '0;
            upool_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            kpool_reg   <= kpool_next;
            upool_reg   <= upool_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg     <= m_status_next;
        m_alloc_addr_reg <= m_alloc_addr_next;
        m_free_count_reg <= m_free_count_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_alloc_addr = m_alloc_addr_reg;
    assign m_free_count = m_free_count_reg;

    `TPFS_ASSERT(a_kpool_count_le_size, kpool_reg.count <= kpool_reg.size)
    `TPFS_ASSERT(a_upool_count_le_size, upool_reg.count <= upool_reg.size)
    `TPFS_ASSERT(a_mark_le_count, (kpool_reg.mark <= kpool_reg.count) && (upool_reg.mark <= upool_reg.count))

endmodule

`default_nettype wire

/* design/tpfs_ctrl.sv */
// ----------------------------------------------------------------------------
// tpfs_ctrl
// Request sequencer: capture, execute, optional stack read, then commit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_pool_page_free_stack_assert.svh"

module tpfs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tpfs_pkg::dp_sts_t  sts,
    output tpfs_pkg::ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd.load_req = 1'b0;
        cmd.commit   = 1'b0;
        cmd.from_mem = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                // stack read is issued this cycle; data shows up in S_READ
                if (sts.need_mem) begin
                    state_next = S_READ;
                end else if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                if (!sts.out_busy) begin
                    cmd.commit   = 1'b1;
                    cmd.from_mem = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `TPFS_NEVER(a_no_result_overwrite, cmd.commit && sts.out_busy)
    `TPFS_ASSERT(a_read_needs_mem, (state_reg == S_READ) |-> $past(sts.need_mem))
    `TPFS_ASSERT(a_single_commit, cmd.commit |=> !cmd.commit)

endmodule

`default_nettype wire

/* design/two_pool_page_free_stack.sv */
// Sequence: init, free, and allocs served from the untouched low part of a pool
//   go from capture through S_EXEC to the commit; an alloc that reads the stack
//   RAM also passes through S_READ for the registered read.
// Requests are taken one at a time; a result not taken stalls the next.
// Reset: synchronous active-low; clears config, pool counts, marks and bounds.
//   Stack RAM is not cleared: per-pool marks stand in for unwritten slots.
// ----------------------------------------------------------------------------
// two_pool_page_free_stack
// Kernel/user page allocator: two LIFO free-page stacks sharing one RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module two_pool_page_free_stack (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tpfs_pkg::REQ_W-1:0]    s_req_type,
    input  logic                          s_in_kernel,
    input  logic [tpfs_pkg::ADDR_W-1:0]   s_page_addr,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tpfs_pkg::STATUS_W-1:0] m_status,
    output logic [tpfs_pkg::ADDR_W-1:0]   m_alloc_addr,
    output logic [tpfs_pkg::FCOUNT_W-1:0] m_free_count,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpfs_pkg::CFG_AW-1:0]   paddr,
    input  logic [tpfs_pkg::CFG_DW-1:0]   pwdata,
    output logic [tpfs_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    tpfs_pkg::ctl_cmd_t cmd;
    tpfs_pkg::dp_sts_t  sts;
    tpfs_pkg::cfg_wr_t  cfg_wr;

    assign pready      = 1'b1;
    assign cfg_wr.en   = psel && penable && pwrite && pready;
    assign cfg_wr.idx  = paddr[3:2];
    assign cfg_wr.data = pwdata;

    tpfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tpfs_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_req_type   (s_req_type),
        .s_in_kernel  (s_in_kernel),
        .s_page_addr  (s_page_addr),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr       (cfg_wr),
        .cfg_rd_idx   (paddr[3:2]),
        .cfg_rdata    (prdata),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_status     (m_status),
        .m_alloc_addr (m_alloc_addr),
        .m_free_count (m_free_count)
    );

endmodule

`default_nettype wire

/* tb/page_grant_checker.sv */
// ----------------------------------------------------------------------------
// page_grant_checker
// Watches the request, answer and APB channels of the two-pool page
// allocator, predicts every answer from its own copy of both free stacks and
// compares each accepted answer with the oldest predicted one.
// ----------------------------------------------------------------------------
module page_grant_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [tpfs_pkg::REQ_W-1:0]    s_req_type,
    input  logic                          s_in_kernel,
    input  logic [tpfs_pkg::ADDR_W-1:0]   s_page_addr,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [tpfs_pkg::STATUS_W-1:0] m_status,
    input  logic [tpfs_pkg::ADDR_W-1:0]   m_alloc_addr,
    input  logic [tpfs_pkg::FCOUNT_W-1:0] m_free_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpfs_pkg::CFG_AW-1:0]   paddr,
    input  logic [tpfs_pkg::CFG_DW-1:0]   pwdata,
    input  logic                          pready,
    output int                            failures,
    output int                            pending,
    output int                            checked,
    output int                            empty_hits,
    output int                            full_hits
);
    import tpfs_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   alloc_addr;
        logic [FCOUNT_W-1:0] free_count;
    } answer_t;

    answer_t awaited_answers[$];
    answer_t want;

    logic [PAGE_W-1:0]   reg_start;
    logic [PAGE_W-1:0]   reg_end;
    logic [KPAGES_W-1:0] reg_kpages;

    // per-pool state, index 1 is the kernel pool
    logic [PAGE_W-1:0] stack_mem [0:1][0:POOL_PAGES-1];
    int unsigned       depth [0:1];
    int unsigned       fresh_mark [0:1];
    logic [PAGE_W-1:0] pool_lo [0:1];
    logic [PAGE_W-1:0] pool_hi [0:1];

    task automatic predict_answer(input logic [REQ_W-1:0] req, input logic kern,
                                  input logic [ADDR_W-1:0] addr, output answer_t ans);
        int                p;
        longint unsigned   s;
        longint unsigned   e;
        longint unsigned   k;
        int unsigned       slot;
        int unsigned       span;
        logic [PAGE_W-1:0] page;
        logic [ADDR_W-1:0] wide;
        p = kern ? 1 : 0;
        ans = '0;
        case (req)
            REQ_INIT: begin
                s = reg_start;
                e = reg_end;
                k = reg_kpages;
                if (s > e || k > e - s || k > POOL_PAGES || e - s - k > POOL_PAGES) begin
                    ans.status = ST_BAD_CFG;
                end else begin
                    pool_lo[1]    = s;
                    pool_hi[1]    = s + k;
                    depth[1]      = k;
                    fresh_mark[1] = k;
                    pool_lo[0]    = s + k;
                    pool_hi[0]    = e;
                    depth[0]      = e - s - k;
                    fresh_mark[0] = e - s - k;
                end
            end
            REQ_ALLOC: begin
                if (depth[p] == 0) begin
                    ans.status = ST_EXHAUSTED;
                end else begin
                    slot = depth[p] - 1;
                    // slots below the mark were never written: implicit low + slot
                    if (slot < fresh_mark[p]) begin
                        page          = pool_lo[p] + slot;
                        fresh_mark[p] = slot;
                    end else begin
                        page = stack_mem[p][slot];
                    end
                    depth[p] = slot;
                    wide = page;
                    ans.alloc_addr = (wide << PAGE_SHIFT) & ADDR_MASK;
                end
            end
            REQ_FREE: begin
                wide = addr & ADDR_MASK;
                page = wide >> PAGE_SHIFT;
                span = pool_hi[p] - pool_lo[p];
                if (wide[PAGE_SHIFT-1:0] != '0) begin
                    ans.status = ST_MISALIGNED;
                end else if (page < pool_lo[p] || page >= pool_hi[p]) begin
                    ans.status = ST_RANGE;
                end else if (depth[p] >= span || depth[p] >= POOL_PAGES) begin
                    ans.status = ST_FULL;
                end else begin
                    stack_mem[p][depth[p]] = page;
                    depth[p]++;
                end
            end
            default: ;
        endcase
        ans.free_count = depth[p];
    endtask

    function automatic bit note_failure();
        failures++;
        return failures <= 10;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            reg_start  = '0;
            reg_end    = '0;
            reg_kpages = '0;
            for (int i = 0; i < 2; i++) begin
                depth[i]      = 0;
                fresh_mark[i] = 0;
                pool_lo[i]    = '0;
                pool_hi[i]    = '0;
            end
            awaited_answers.delete();
            failures   = 0;
            checked    = 0;
            empty_hits = 0;
            full_hits  = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_AW-1:2])
                    CFG_START:  reg_start  = pwdata[PAGE_W-1:0];
                    CFG_END:    reg_end    = pwdata[PAGE_W-1:0];
                    CFG_KPAGES: reg_kpages = pwdata[KPAGES_W-1:0];
                    default: ;
                endcase
            end
            // answers first: one taken at this edge belongs to an older request
            if (m_valid && m_ready) begin
                checked++;
                if (m_status == ST_EXHAUSTED) empty_hits++;
                if (m_status == ST_FULL) full_hits++;
                if (awaited_answers.size() == 0) begin
                    if (note_failure())
                        $display("unexpected answer: status %0d addr %h count %0d",
                                 m_status, m_alloc_addr, m_free_count);
                end else begin
                    want = awaited_answers.pop_front();
                    if (m_status !== want.status || m_alloc_addr !== want.alloc_addr ||
                        m_free_count !== want.free_count) begin
                        if (note_failure())
                            $display({"answer mismatch: expected status %0d addr %h count %0d,",
                                      " got status %0d addr %h count %0d"},
                                     want.status, want.alloc_addr, want.free_count,
                                     m_status, m_alloc_addr, m_free_count);
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_answer(s_req_type, s_in_kernel, s_page_addr, want);
                awaited_answers.push_back(want);
            end
        end
        pending = awaited_answers.size();
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the two-pool page allocator: a directed pass over the error cases
// and region corners, then random phases under several region settings with
// random gaps on both channels, a long answer stall and full drains.
// ----------------------------------------------------------------------------
module testbench;
    import tpfs_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type;
    logic                s_in_kernel;
    logic [ADDR_W-1:0]   s_page_addr;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [ADDR_W-1:0]   m_alloc_addr;
    logic [FCOUNT_W-1:0] m_free_count;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    int failures;
    int pending;
    int checked;
    int empty_hits;
    int full_hits;

    bit                  no_idle;
    bit                  hold_results;
    int                  sent_total;
    int                  settings_used;
    logic [PAGE_W-1:0]   cur_start;
    logic [PAGE_W-1:0]   cur_end;
    logic [KPAGES_W-1:0] cur_kpages;

    two_pool_page_free_stack dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_in_kernel  (s_in_kernel),
        .s_page_addr  (s_page_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_alloc_addr (m_alloc_addr),
        .m_free_count (m_free_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    page_grant_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_in_kernel  (s_in_kernel),
        .s_page_addr  (s_page_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_alloc_addr (m_alloc_addr),
        .m_free_count (m_free_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .failures     (failures),
        .pending      (pending),
        .checked      (checked),
        .empty_hits   (empty_hits),
        .full_hits    (full_hits)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // answer side: random hold-off per answer, one long stall on request
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (80) @(negedge aclk);
                hold_results = 1'b0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 6);
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // called and returns at a falling edge; valid stays high for a back-to-back request
    task automatic send_req(input logic [REQ_W-1:0] req, input logic kern,
                            input logic [ADDR_W-1:0] addr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_in_kernel <= kern;
        s_page_addr <= addr;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
        sent_total++;
    endtask

    task automatic wait_all_answered();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_region(input logic [PAGE_W-1:0] s, input logic [PAGE_W-1:0] e,
                              input logic [KPAGES_W-1:0] k);
        write_reg(CFG_START, s);
        write_reg(CFG_END, e);
        write_reg(CFG_KPAGES, k);
        cur_start  = s;
        cur_end    = e;
        cur_kpages = k;
        settings_used++;
    endtask

    // mostly allocs and in-pool frees, the rest boundary pages, bad offsets and noise
    task automatic send_random();
        int                pick;
        logic              kern;
        logic [PAGE_W-1:0] lo;
        logic [PAGE_W-1:0] hi;
        logic [PAGE_W-1:0] page;
        logic [63:0]       raw;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        kern = $urandom_range(0, 1);
        lo   = kern ? cur_start : cur_start + cur_kpages;
        hi   = kern ? cur_start + cur_kpages : cur_end;
        raw  = {$urandom, $urandom};
        a    = raw[ADDR_W-1:0];
        if (pick < 45) begin
            send_req(REQ_ALLOC, kern, a);
        end else if (pick < 78) begin
            if (hi > lo) page = lo + $urandom_range(0, hi - lo - 1);
            else page = lo;
            a = page;
            send_req(REQ_FREE, kern, a << PAGE_SHIFT);
        end else if (pick < 84) begin
            page = pick[0] ? hi : lo - 1;
            a = page;
            send_req(REQ_FREE, kern, a << PAGE_SHIFT);
        end else if (pick < 90) begin
            a[PAGE_SHIFT-1:0] = $urandom_range(1, (1 << PAGE_SHIFT) - 1);
            send_req(REQ_FREE, kern, a);
        end else if (pick < 95) begin
            send_req(REQ_FREE, kern, a);
        end else if (pick < 98) begin
            send_req(REQ_UNUSED, kern, a);
        end else begin
            send_req(REQ_INIT, kern, a);
        end
    endtask

    task automatic run_phase(input logic [PAGE_W-1:0] s, input logic [PAGE_W-1:0] e,
                             input logic [KPAGES_W-1:0] k, input int n, input bit fast,
                             input int stall_at, input int pause_at);
        wait_all_answered();
        no_idle = fast;
        set_region(s, e, k);
        send_req(REQ_INIT, $urandom_range(0, 1), '0);
        for (int i = 0; i < n; i++) begin
            if (i == stall_at) hold_results = 1'b1;
            if (i == pause_at) wait_all_answered();
            send_random();
        end
    endtask

    initial begin
        logic [PAGE_W-1:0] rs;
        int                sz;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = REQ_INIT;
        s_in_kernel  = 1'b0;
        s_page_addr  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        no_idle      = 1'b0;
        hold_results = 1'b0;
        sent_total   = 0;
        settings_used = 0;
        cur_start    = '0;
        cur_end      = '0;
        cur_kpages   = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // nothing set up yet: empty pools with zero bounds
        send_req(REQ_ALLOC, 1'b1, '0);
        send_req(REQ_FREE, 1'b0, '0);
        send_req(REQ_UNUSED, 1'b1, '1);
        send_req(REQ_INIT, 1'b0, '0);

        wait_all_answered();
        set_region(28'h100, 28'h108, 11'd3);
        send_req(REQ_INIT, 1'b1, '0);
        repeat (4) send_req(REQ_ALLOC, 1'b1, '0);
        send_req(REQ_FREE, 1'b1, 40'h00_0010_2000);
        send_req(REQ_FREE, 1'b1, 40'h00_0010_0000);
        send_req(REQ_ALLOC, 1'b1, '0);
        send_req(REQ_FREE, 1'b1, 40'h00_0010_0001);
        send_req(REQ_FREE, 1'b1, '1);
        send_req(REQ_FREE, 1'b1, 40'h00_0010_3000);
        send_req(REQ_FREE, 1'b1, 40'h00_000F_F000);
        send_req(REQ_FREE, 1'b1, 40'h00_0010_1000);
        send_req(REQ_FREE, 1'b1, 40'h00_0010_0000);
        send_req(REQ_FREE, 1'b1, 40'h00_0010_2000);
        send_req(REQ_ALLOC, 1'b0, '0);
        send_req(REQ_FREE, 1'b0, 40'hFF_FFFF_F000);

        // bad regions must leave both pools as they are; the last, with no kernel pages, is valid and empty
        wait_all_answered();
        write_reg(CFG_START, 32'h200);
        send_req(REQ_INIT, 1'b0, '0);
        wait_all_answered();
        write_reg(CFG_START, 32'h100);
        write_reg(CFG_KPAGES, 32'hFFFF_FFFF);
        send_req(REQ_INIT, 1'b1, '0);
        wait_all_answered();
        write_reg(CFG_START, 32'h0);
        write_reg(CFG_END, 32'hFFFF_FFFF);
        write_reg(CFG_KPAGES, POOL_PAGES);
        send_req(REQ_INIT, 1'b0, '0);
        send_req(REQ_ALLOC, 1'b0, '0);
        wait_all_answered();
        write_reg(CFG_START, 32'hFFFF_FFFF);
        send_req(REQ_INIT, 1'b1, '0);
        wait_all_answered();
        write_reg(CFG_KPAGES, 32'h0);
        send_req(REQ_INIT, 1'b0, '0);
        send_req(REQ_FREE, 1'b0, 40'hFF_FFFF_F000);
        settings_used += 5;

        run_phase(28'h40, 28'h58, 11'd10, 80, 1'b0, 20, -1);
        rs = $urandom_range(0, 28'hFFF_FF00);
        sz = $urandom_range(1, 30);
        run_phase(rs, rs + sz, $urandom_range(0, sz), 80, 1'b1, -1, -1);
        run_phase(28'h1000, 28'h1010, 11'd0, 80, 1'b0, -1, 40);
        run_phase(28'h2000, 28'h2012, 11'd18, 80, 1'b0, -1, -1);
        run_phase(28'hFFF_F7FF, 28'hFFF_FFFF, POOL_PAGES, 80, 1'b1, -1, -1);
        run_phase(28'h0, 28'h6, 11'd3, 80, 1'b0, -1, -1);
        rs = $urandom_range(0, 28'hFFF_FF00);
        sz = $urandom_range(1, 30);
        run_phase(rs, rs + sz, $urandom_range(0, sz), 70, 1'b0, -1, 30);

        wait_all_answered();
        repeat (8) @(negedge aclk);
        $display("covered %0d requests under %0d region settings, %0d answers checked",
                 sent_total, settings_used, checked);
        $display("answers with empty pool: %0d, with full pool: %0d", empty_hits, full_hits);
        if (failures == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
